// File: rtl/kbd_pkg.sv
package kbd_pkg;

  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned PtrW       = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned LvlW       = 8;
  localparam int unsigned CharW      = 7;

  localparam logic [7:0] KEY_LSHIFT_DOWN = 8'h2A;
  localparam logic [7:0] KEY_RSHIFT_DOWN = 8'h36;
  localparam logic [7:0] KEY_LSHIFT_UP   = 8'hAA;
  localparam logic [7:0] KEY_RSHIFT_UP   = 8'hB6;
  localparam logic [7:0] KEY_CAPS_DOWN   = 8'h3A;

  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] scan_code;
  } kbd_in_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             char_valid;
    logic [LvlW-1:0]  chars_waiting;
    logic             char_dropped;
  } kbd_out_t;

  // per-word fifo status toward the result register
  typedef struct packed {
    logic            popped;
    logic            dropped;
    logic [LvlW-1:0] level;
  } kbd_fifo_stat_t;

  function automatic logic [CharW-1:0] map_lower(input logic [5:0] code);
    logic [7:0] c;
    case (code)
      6'h02: c = "1";
      6'h03: c = "2";
      6'h04: c = "3";
      6'h05: c = "4";
      6'h06: c = "5";
      6'h07: c = "6";
      6'h08: c = "7";
      6'h09: c = "8";
      6'h0A: c = "9";
      6'h0B: c = "0";
      6'h0C: c = "-";
      6'h0D: c = "=";
      6'h0E: c = 8'h08;
      6'h0F: c = 8'h09;
      6'h10: c = "q";
      6'h11: c = "w";
      6'h12: c = "e";
      6'h13: c = "r";
      6'h14: c = "t";
      6'h15: c = "y";
      6'h16: c = "u";
      6'h17: c = "i";
      6'h18: c = "o";
      6'h19: c = "p";
      6'h1A: c = "[";
      6'h1B: c = "]";
      6'h1C: c = 8'h0A;
      6'h1E: c = "a";
      6'h1F: c = "s";
      6'h20: c = "d";
      6'h21: c = "f";
      6'h22: c = "g";
      6'h23: c = "h";
      6'h24: c = "j";
      6'h25: c = "k";
      6'h26: c = "l";
      6'h27: c = ";";
      6'h28: c = 8'h27;
      6'h29: c = 8'h60;
      6'h2B: c = 8'h5C;
      6'h2C: c = "z";
      6'h2D: c = "x";
      6'h2E: c = "c";
      6'h2F: c = "v";
      6'h30: c = "b";
      6'h31: c = "n";
      6'h32: c = "m";
      6'h33: c = ",";
      6'h34: c = ".";
      6'h35: c = "/";
      6'h37: c = "*";
      6'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c[CharW-1:0];
  endfunction

  function automatic logic [CharW-1:0] map_upper(input logic [5:0] code);
    logic [7:0] c;
    case (code)
      6'h02: c = "!";
      6'h03: c = "@";
      6'h04: c = "#";
      6'h05: c = "$";
      6'h06: c = "%";
      6'h07: c = "^";
      6'h08: c = "&";
      6'h09: c = "*";
      6'h0A: c = "(";
      6'h0B: c = ")";
      6'h0C: c = "_";
      6'h0D: c = "+";
      6'h0E: c = 8'h08;
      6'h0F: c = 8'h09;
      6'h10: c = "Q";
      6'h11: c = "W";
      6'h12: c = "E";
      6'h13: c = "R";
      6'h14: c = "T";
      6'h15: c = "Y";
      6'h16: c = "U";
      6'h17: c = "I";
      6'h18: c = "O";
      6'h19: c = "P";
      6'h1A: c = "{";
      6'h1B: c = "}";
      6'h1C: c = 8'h0A;
      6'h1E: c = "A";
      6'h1F: c = "S";
      6'h20: c = "D";
      6'h21: c = "F";
      6'h22: c = "G";
      6'h23: c = "H";
      6'h24: c = "J";
      6'h25: c = "K";
      6'h26: c = "L";
      6'h27: c = ":";
      6'h28: c = 8'h22;
      6'h29: c = "~";
      6'h2B: c = "|";
      6'h2C: c = "Z";
      6'h2D: c = "X";
      6'h2E: c = "C";
      6'h2F: c = "V";
      6'h30: c = "B";
      6'h31: c = "N";
      6'h32: c = "M";
      6'h33: c = "<";
      6'h34: c = ">";
      6'h35: c = "?";
      6'h37: c = "*";
      6'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c[CharW-1:0];
  endfunction

endpackage

// File: rtl/kbd_decode.sv
module kbd_decode import kbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  kbd_in_t          item_i,
  output logic [CharW-1:0] key_char_o
);

  logic shift_q, shift_d;
  logic caps_q, caps_d;
  logic is_scan;

  assign is_scan = accept_i && (item_i.cmd == CMD_SCAN);

  always_comb begin
    shift_d = shift_q;
    caps_d  = caps_q;
    if (is_scan) begin
      if (item_i.scan_code == KEY_LSHIFT_DOWN || item_i.scan_code == KEY_RSHIFT_DOWN) begin
        shift_d = 1'b1;
      end else if (item_i.scan_code == KEY_LSHIFT_UP ||
                   item_i.scan_code == KEY_RSHIFT_UP) begin
        shift_d = 1'b0;
      end else if (item_i.scan_code == KEY_CAPS_DOWN) begin
        caps_d = ~caps_q;
      end
    end
  end

  // release codes and codes 0x40 and up give no character; shift and caps
  // make codes have zero table entries
  always_comb begin
    if (item_i.scan_code[7:6] != 2'b00) begin
      key_char_o = '0;
    end else if (shift_q ^ caps_q) begin
      key_char_o = map_upper(item_i.scan_code[5:0]);
    end else begin
      key_char_o = map_lower(item_i.scan_code[5:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
    end
  end

endmodule

// File: rtl/kbd_fifo.sv
module kbd_fifo import kbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [CharW-1:0] push_data_i,
  input  logic             pop_i,
  output logic [CharW-1:0] rd_data_o,
  output kbd_fifo_stat_t   stat_o
);

  localparam logic [LvlW-1:0] FullLvl = LvlW'(FIFO_DEPTH - 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FIFO_DEPTH - 1);

  logic [CharW-1:0] mem_q [FIFO_DEPTH];
  logic [CharW-1:0] rd_data_q;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0]  count_q, count_d;
  logic             empty, full, push_ok, pop_ok, drop;

  assign empty   = (count_q == '0);
  assign full    = (count_q == FullLvl);
  assign push_ok = push_i && !full;
  assign pop_ok  = pop_i && !empty;
  assign drop    = push_i && full;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q + LvlW'(push_ok) - LvlW'(pop_ok);
  end

  assign stat_o.popped  = pop_ok;
  assign stat_o.dropped = drop;
  assign stat_o.level   = count_d;
  assign rd_data_o      = rd_data_q;

  // read and write never hit the same slot: a pop needs a nonempty fifo
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
    if (pop_ok) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullLvl) else $error("fifo level above capacity");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (wr_ptr_q == rd_ptr_q)) else $error("level and pointers disagree");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop |=> (count_q == FullLvl)) else $error("fifo left full state after drop");

  a_pop_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok |=> (count_q == $past(count_q) - LvlW'(1))) else $error("pop did not lower level");

endmodule

// File: rtl/keyboard_scancode_to_ascii_fifo.sv
// channel  | ports                   | handshake
// ---------+-------------------------+---------------------------------------
// input    | start, busy, item_i     | word taken at edge with start & !busy
// result   | valid_o, result_o       | one-cycle strobe, word taken at its end
//
// one word accepted every cycle; busy stays low
// each result appears on the cycle right after its word is accepted
// the latency is set by the registered read port of the character memory
// reset (rst_ni low, asynchronous) clears flags, pointers, level and strobe
// the receiver cannot stall, so no result is ever held back
module keyboard_scancode_to_ascii_fifo import kbd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  kbd_in_t  item_i,
  output logic     valid_o,
  output kbd_out_t result_o
);

  logic             accept;
  logic [CharW-1:0] key_char;
  logic             push, pop;
  logic [CharW-1:0] rd_data;
  kbd_fifo_stat_t   stat;
  kbd_fifo_stat_t   res_q;
  logic             valid_q;

  // every word completes in a single pass, so input is always open
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // shift and caps tracking plus table lookup
  kbd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .key_char_o (key_char)
  );

  // a scan word pushes only a nonzero character; a read word pops
  assign push = accept && (item_i.cmd == CMD_SCAN) && (key_char != '0);
  assign pop  = accept && (item_i.cmd == CMD_READ);

  kbd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (key_char),
    .pop_i       (pop),
    .rd_data_o   (rd_data),
    .stat_o      (stat)
  );

  // result register, side by side with the memory read register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= stat;
    end
  end

  // popped character only when the read found data, else zero
  assign valid_o                = valid_q;
  assign result_o.char_out      = res_q.popped ? rd_data : '0;
  assign result_o.char_valid    = res_q.popped;
  assign result_o.chars_waiting = res_q.level;
  assign result_o.char_dropped  = res_q.dropped;

endmodule

// File: tb/keyboard_scancode_to_ascii_fifo_tb.sv
`timescale 1ns / 1ps

module keyboard_scancode_to_ascii_fifo_tb;
  import kbd_pkg::*;

  // the limit is generous for the slowest legal run
  localparam int unsigned LIMIT_CYCLES = 20000;
  // accepted-word window in which the driver never idles (covers the fill burst)
  localparam int unsigned QUIET_FIRST  = 40;
  localparam int unsigned QUIET_LAST   = 320;
  localparam int unsigned IDLE_PCT     = 17;
  localparam logic [7:0]  KEY_CTRL_DOWN = 8'h1D;
  localparam logic [7:0]  KEY_CTRL_UP   = 8'h9D;
  localparam logic [7:0]  RELEASE_BIT   = 8'h80;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  kbd_in_t  item_i;
  logic     valid_o;
  kbd_out_t result_o;

  keyboard_scancode_to_ascii_fifo u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  // set-1 key layout, unshifted; zero marks a code with no character
  logic [7:0] lower_key [0:63] = '{
    8'h00, 8'h00, "1",   "2",   "3",   "4",   "5",   "6",
    "7",   "8",   "9",   "0",   "-",   "=",   8'h08, 8'h09,
    "q",   "w",   "e",   "r",   "t",   "y",   "u",   "i",
    "o",   "p",   "[",   "]",   8'h0A, 8'h00, "a",   "s",
    "d",   "f",   "g",   "h",   "j",   "k",   "l",   ";",
    8'h27, 8'h60, 8'h00, 8'h5C, "z",   "x",   "c",   "v",
    "b",   "n",   "m",   ",",   ".",   "/",   8'h00, "*",
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // same layout with shift xor caps in effect
  logic [7:0] upper_key [0:63] = '{
    8'h00, 8'h00, "!",   "@",   "#",   "$",   "%",   "^",
    "&",   "*",   "(",   ")",   "_",   "+",   8'h08, 8'h09,
    "Q",   "W",   "E",   "R",   "T",   "Y",   "U",   "I",
    "O",   "P",   "{",   "}",   8'h0A, 8'h00, "A",   "S",
    "D",   "F",   "G",   "H",   "J",   "K",   "L",   ":",
    8'h22, "~",   8'h00, "|",   "Z",   "X",   "C",   "V",
    "B",   "N",   "M",   "<",   ">",   "?",   8'h00, "*",
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // shadow of the keyboard state and character ring
  logic [CharW-1:0] key_store [FIFO_DEPTH];
  int unsigned      wr_idx     = 0;
  int unsigned      rd_idx     = 0;
  logic             shift_down = 1'b0;
  logic             caps_on    = 1'b0;

  kbd_in_t     keystroke_q [$];  // words still to be driven
  kbd_out_t    decoded_q   [$];  // predicted status words, oldest first
  bit          word_taken;       // word on item_i was accepted at the last rising edge
  int unsigned n_taken;
  int unsigned n_errors;

  // advance the shadow state by one word and return the status it should produce
  function automatic kbd_out_t decode_key_word(kbd_in_t w);
    kbd_out_t         r;
    logic [CharW-1:0] ch;
    r  = '0;
    ch = '0;
    if (w.cmd == CMD_READ) begin
      // an empty ring gives an all-zero status
      if (wr_idx != rd_idx) begin
        r.char_out   = key_store[rd_idx];
        r.char_valid = 1'b1;
        rd_idx       = (rd_idx + 1) % FIFO_DEPTH;
      end
    end else if (w.scan_code == KEY_LSHIFT_DOWN || w.scan_code == KEY_RSHIFT_DOWN) begin
      shift_down = 1'b1;
    end else if (w.scan_code == KEY_LSHIFT_UP || w.scan_code == KEY_RSHIFT_UP) begin
      shift_down = 1'b0;
    end else if (w.scan_code == KEY_CAPS_DOWN) begin
      caps_on = !caps_on;
    end else if (!w.scan_code[7] && w.scan_code < 8'h40) begin
      // releases and codes past the table fall through with no effect
      if (shift_down ^ caps_on) begin
        ch = upper_key[w.scan_code[5:0]][CharW-1:0];
      end else begin
        ch = lower_key[w.scan_code[5:0]][CharW-1:0];
      end
      if (ch != '0) begin
        // one slot always stays free, so the ring holds depth - 1 characters
        if ((wr_idx + 1) % FIFO_DEPTH == rd_idx) begin
          r.char_dropped = 1'b1;
        end else begin
          key_store[wr_idx] = ch;
          wr_idx            = (wr_idx + 1) % FIFO_DEPTH;
        end
      end
    end
    r.chars_waiting = LvlW'((wr_idx + FIFO_DEPTH - rd_idx) % FIFO_DEPTH);
    return r;
  endfunction

  task automatic add_word(input logic c, input logic [7:0] code);
    kbd_in_t w;
    w.cmd       = c;
    w.scan_code = code;
    keystroke_q.push_back(w);
  endtask

  // a press code that always decodes to a character
  function automatic logic [7:0] char_code();
    logic [7:0] c;
    c = 8'($urandom_range(0, 63));
    while (lower_key[c[5:0]] == 8'h00) begin
      c = 8'($urandom_range(0, 63));
    end
    return c;
  endfunction

  // realistic typing: plain and shifted keys, releases, caps, reads, plus some noise
  task automatic add_typing(input int unsigned n);
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        add_word(CMD_SCAN, char_code());
      end else if (pick < 40) begin
        add_word(CMD_SCAN, $urandom_range(0, 1) ? KEY_LSHIFT_DOWN : KEY_RSHIFT_DOWN);
        add_word(CMD_SCAN, char_code());
        add_word(CMD_SCAN, $urandom_range(0, 1) ? KEY_LSHIFT_UP : KEY_RSHIFT_UP);
      end else if (pick < 48) begin
        add_word(CMD_SCAN, char_code() | RELEASE_BIT);
      end else if (pick < 53) begin
        add_word(CMD_SCAN, KEY_CAPS_DOWN);
      end else if (pick < 80) begin
        add_word(CMD_READ, 8'($urandom_range(0, 255)));
      end else begin
        add_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // free-running clock, 12 ns period
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // driver: presents words on the falling edge; a word stays put until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!start || word_taken)) begin
      if (keystroke_q.size() != 0 &&
          !($urandom_range(0, 99) < IDLE_PCT &&
            (n_taken < QUIET_FIRST || n_taken > QUIET_LAST))) begin
        start  <= 1'b1;
        item_i <= keystroke_q.pop_front();
      end else begin
        start  <= 1'b0;
      end
    end
  end

  // monitor: predicts on acceptance, then checks the strobe of the ending cycle
  always @(posedge clk_i) begin
    kbd_out_t want;
    if (!rst_ni) begin
      word_taken = 1'b0;
    end else begin
      word_taken = start && !busy;
      // predict first, so the check below works for any latency
      if (word_taken) begin
        decoded_q.push_back(decode_key_word(item_i));
        n_taken++;
      end
      if (valid_o) begin
        if (decoded_q.size() == 0) begin
          $error("status word with nothing expected: %h", result_o);
          n_errors++;
        end else begin
          want = decoded_q.pop_front();
          if (result_o.char_out !== want.char_out) begin
            $error("char_out: expected %h, got %h", want.char_out, result_o.char_out);
            n_errors++;
          end
          if (result_o.char_valid !== want.char_valid) begin
            $error("char_valid: expected %b, got %b", want.char_valid, result_o.char_valid);
            n_errors++;
          end
          if (result_o.chars_waiting !== want.chars_waiting) begin
            $error("chars_waiting: expected %0d, got %0d",
                   want.chars_waiting, result_o.chars_waiting);
            n_errors++;
          end
          if (result_o.char_dropped !== want.char_dropped) begin
            $error("char_dropped: expected %b, got %b",
                   want.char_dropped, result_o.char_dropped);
            n_errors++;
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("keyboard_scancode_to_ascii_fifo regression: fail");
    $finish;
  end

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    item_i   = '0;
    n_taken  = 0;
    n_errors = 0;

    // directed: empty read, table edges, ignored codes, shift and caps handling
    add_word(CMD_READ, 8'hFF);
    add_word(CMD_SCAN, 8'h00);
    add_word(CMD_SCAN, 8'h02);
    add_word(CMD_SCAN, 8'h3F);
    add_word(CMD_SCAN, 8'h40);
    add_word(CMD_SCAN, 8'hFF);
    add_word(CMD_SCAN, 8'h82);
    add_word(CMD_SCAN, KEY_CTRL_DOWN);
    add_word(CMD_SCAN, KEY_CTRL_UP);
    add_word(CMD_SCAN, KEY_LSHIFT_DOWN);
    add_word(CMD_SCAN, 8'h10);
    add_word(CMD_SCAN, KEY_LSHIFT_UP);
    add_word(CMD_SCAN, KEY_RSHIFT_DOWN);
    add_word(CMD_SCAN, 8'h28);
    add_word(CMD_SCAN, KEY_RSHIFT_UP);
    add_word(CMD_SCAN, KEY_CAPS_DOWN);
    add_word(CMD_SCAN, 8'h2C);
    // shift while caps is on cancels back to lower case
    add_word(CMD_SCAN, KEY_LSHIFT_DOWN);
    add_word(CMD_SCAN, 8'h29);
    add_word(CMD_SCAN, KEY_LSHIFT_UP);
    add_word(CMD_SCAN, KEY_CAPS_DOWN);
    add_word(CMD_SCAN, 8'h0E);
    add_word(CMD_SCAN, 8'h1C);
    add_word(CMD_SCAN, 8'h39);
    repeat (6) add_word(CMD_READ, 8'($urandom_range(0, 255)));

    // random typing, then fill past full so characters drop, then drain past empty
    add_typing(10);
    repeat (256) add_word(CMD_SCAN, char_code());
    repeat (256) add_word(CMD_READ, 8'($urandom_range(0, 255)));
    add_typing(10);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain: all words taken and every status word seen
    while (keystroke_q.size() != 0 || start || decoded_q.size() != 0) begin
      @(posedge clk_i);
    end
    // then wait on to catch stray strobes
    repeat (4) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("keyboard_scancode_to_ascii_fifo regression: pass");
    end else begin
      $display("keyboard_scancode_to_ascii_fifo regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kbd_pkg.sv
rtl/kbd_decode.sv
rtl/kbd_fifo.sv
rtl/keyboard_scancode_to_ascii_fifo.sv
tb/keyboard_scancode_to_ascii_fifo_tb.sv
